FILE: design/smg_pkg.sv
// Shared constants and types for the shuffled congruential generator.
`timescale 1ns / 1ps

package smg_pkg;

  localparam int MODULUS_BITS        = 31;
  localparam int VALUE_W             = 31;
  localparam int TABLE_DEPTH_DEFAULT = 32;
  localparam int CFG_INDEX_W         = 8;
  localparam int IN_TDATA_W          = 32;
  localparam int OUT_TDATA_W         = 64;

  localparam logic [MODULUS_BITS-1:0] SEED_RESET = MODULUS_BITS'(24389);
  localparam logic [VALUE_W-1:0]      MULT_RESET = VALUE_W'(24389);

  localparam logic [CFG_INDEX_W-1:0] CFG_SEED       = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_MULTIPLIER = CFG_INDEX_W'(1);

  typedef struct packed {
    logic valid;
    logic fill;
  } smg_ctl_t;

endpackage

FILE: design/shuffled_mcg_generator_top.sv
// Top level of the shuffled multiplicative congruential generator.
`timescale 1ns / 1ps

// The block takes one fresh value per cycle and, once its table holds TABLE_DEPTH values,
// returns one shuffled value per cycle, both while the output is not stalled. The first
// TABLE_DEPTH transactions only fill the table and give no result. Each later transaction
// advances the generator (state = multiplier * state mod 2^31) and returns the table entry
// picked by the new state together with that state, then replaces the entry with the fresh
// value. The generator multiply, the index scaling and the table access each end in a
// register, and the result register lets two more inputs be taken while a result waits.
// Writing the seed register reloads the generator state at once; both registers should be
// written only when no transaction is in flight.

module shuffled_mcg_generator_top import smg_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [VALUE_W-1:0]     cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [30:0] fresh_value
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // [30:0] shuffled_value, [61:31] generator_value
);

  smg_ctl_t                ctl1;
  smg_ctl_t                ctl2;
  logic [IDX_W-1:0]        fill_addr1;
  logic [IDX_W-1:0]        idx2;
  logic [VALUE_W-1:0]      fresh1;
  logic [VALUE_W-1:0]      fresh2;
  logic [MODULUS_BITS-1:0] state1;
  logic [MODULUS_BITS-1:0] state2;
  logic [VALUE_W-1:0]      shuffled_value;
  logic [VALUE_W-1:0]      generator_value;
  logic                    out_free;
  logic                    take2;
  logic                    load2;
  logic                    load1;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign take2     = ctl2.valid && (ctl2.fill || out_free);
  assign load2     = !ctl2.valid || take2;
  assign load1     = !ctl1.valid || load2;
  assign s_tready  = load1;

  assign m_tdata = {(OUT_TDATA_W - 2 * VALUE_W)'(0), generator_value, shuffled_value};

  smg_gen #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_gen (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_value  (s_tdata[VALUE_W-1:0]),
    .load      (load1),
    .ctl       (ctl1),
    .fill_addr (fill_addr1),
    .fresh     (fresh1),
    .state     (state1)
  );

  smg_index #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_index (
    .clk       (clk),
    .rst       (rst),
    .load      (load2),
    .ctl_in    (ctl1),
    .fill_addr (fill_addr1),
    .fresh_in  (fresh1),
    .state_in  (state1),
    .ctl       (ctl2),
    .idx       (idx2),
    .fresh     (fresh2),
    .state     (state2)
  );

  smg_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk             (clk),
    .rst             (rst),
    .take            (take2),
    .ctl_in          (ctl2),
    .idx             (idx2),
    .fresh           (fresh2),
    .state           (state2),
    .out_ready       (m_tready),
    .out_valid       (m_tvalid),
    .shuffled_value  (shuffled_value),
    .generator_value (generator_value)
  );

endmodule

FILE: design/smg_gen.sv
// Configuration registers, fill counter and congruential generator stage.
`timescale 1ns / 1ps

module smg_gen import smg_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [VALUE_W-1:0]      cfg_data,
  input  logic                    in_valid,
  input  logic [VALUE_W-1:0]      in_value,
  input  logic                    load,
  output smg_ctl_t                ctl,
  output logic [IDX_W-1:0]        fill_addr,
  output logic [VALUE_W-1:0]      fresh,
  output logic [MODULUS_BITS-1:0] state
);

  logic [VALUE_W-1:0]      multiplier;
  logic [CNT_W-1:0]        fill_count;
  logic [MODULUS_BITS-1:0] state_next;
  logic                    filling;
  logic                    accept;

  assign filling    = fill_count < CNT_W'(TABLE_DEPTH);
  assign accept     = in_valid && load;
  assign state_next = MODULUS_BITS'(multiplier * state);

  always_ff @(posedge clk) begin
    if (rst) begin
      multiplier <= MULT_RESET;
      state      <= SEED_RESET;
      fill_count <= '0;
      ctl        <= '0;
    end else begin
      if (cfg_valid && cfg_index == CFG_SEED) begin
        state <= MODULUS_BITS'(cfg_data);
      end else if (accept && !filling) begin
        state <= state_next;
      end
      if (cfg_valid && cfg_index == CFG_MULTIPLIER) begin
        multiplier <= cfg_data;
      end
      if (accept && filling) begin
        fill_count <= fill_count + CNT_W'(1);
      end
      if (load) begin
        ctl.valid <= in_valid;
        ctl.fill  <= filling;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fresh     <= in_value;
      fill_addr <= fill_count[IDX_W-1:0];
    end
  end

endmodule

FILE: design/smg_index.sv
// Table index stage: scales the generator state to an entry number, or passes the fill address while the table fills.
`timescale 1ns / 1ps

module smg_index import smg_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1),
  localparam int PROD_W = MODULUS_BITS + CNT_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  smg_ctl_t                ctl_in,
  input  logic [IDX_W-1:0]        fill_addr,
  input  logic [VALUE_W-1:0]      fresh_in,
  input  logic [MODULUS_BITS-1:0] state_in,
  output smg_ctl_t                ctl,
  output logic [IDX_W-1:0]        idx,
  output logic [VALUE_W-1:0]      fresh,
  output logic [MODULUS_BITS-1:0] state
);

  logic [PROD_W-1:0] scaled;
  logic [IDX_W-1:0]  pick;

  assign scaled = PROD_W'(state_in) * PROD_W'(TABLE_DEPTH);
  assign pick   = ctl_in.fill ? fill_addr : scaled[MODULUS_BITS +: IDX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (load) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load && ctl_in.valid) begin
      idx   <= pick;
      fresh <= fresh_in;
      state <= state_in;
    end
  end

endmodule

FILE: design/smg_table.sv
// Shuffle table with read-then-replace access and the result register.
`timescale 1ns / 1ps

module smg_table import smg_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    take,
  input  smg_ctl_t                ctl_in,
  input  logic [IDX_W-1:0]        idx,
  input  logic [VALUE_W-1:0]      fresh,
  input  logic [MODULUS_BITS-1:0] state,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [VALUE_W-1:0]      shuffled_value,
  output logic [VALUE_W-1:0]      generator_value
);

  logic [VALUE_W-1:0] mem [TABLE_DEPTH];
  logic               emit;

  assign emit = take && !ctl_in.fill;

  always_ff @(posedge clk) begin
    if (take) begin
      mem[idx] <= fresh;
    end
    if (emit) begin
      shuffled_value  <= mem[idx];
      generator_value <= VALUE_W'(state);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: tb/shuffled_mcg_generator_top_test.sv
// Self-checking testbench for the shuffled congruential generator top level.
`timescale 1ns / 1ps

module shuffled_mcg_generator_top_test;
  import smg_pkg::*;

  localparam int DEPTH         = TABLE_DEPTH_DEFAULT;
  localparam int SLOT_W        = $clog2(DEPTH);
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 235;
  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LOW  = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HIGH = '1;

  typedef struct {
    logic [VALUE_W-1:0]      shuffled;
    logic [MODULUS_BITS-1:0] generator;
  } draw_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [VALUE_W-1:0]     cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  logic [MODULUS_BITS-1:0] gen_mult;
  logic [MODULUS_BITS-1:0] gen_state;
  logic [VALUE_W-1:0]      shuffle_copy [DEPTH];
  int                      fill_level;
  draw_t                   pending_draws [$];
  bit                      back_to_back;
  int                      mismatches;
  int                      cycle_count;

  shuffled_mcg_generator_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("shuffled_mcg_generator_top_test NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    $display("%0t: %s got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [VALUE_W-1:0] value);
    if (idx == CFG_SEED) begin
      gen_state = value;
    end else if (idx == CFG_MULTIPLIER) begin
      gen_mult = value;
    end
  endfunction

  function automatic void advance_shuffle(input logic [VALUE_W-1:0] fresh);
    logic [2*MODULUS_BITS-1:0] product;
    logic [SLOT_W-1:0]         slot;
    draw_t                     draw;
    if (fill_level < DEPTH) begin
      shuffle_copy[fill_level] = fresh;
      fill_level++;
      return;
    end
    product            = gen_mult * gen_state;
    gen_state          = product[MODULUS_BITS-1:0];
    slot               = gen_state[MODULUS_BITS-1 -: SLOT_W];
    draw.shuffled      = shuffle_copy[slot];
    draw.generator     = gen_state;
    pending_draws.push_back(draw);
    shuffle_copy[slot] = fresh;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return VALUE_MAX;
      2:       return VALUE_W'(1);
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_fresh(input logic [VALUE_W-1:0] value);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {1'b0, value};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    advance_shuffle(value);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [VALUE_W-1:0] value,
                           input bit last);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, value);
    @(negedge clk);
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_draws.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_burst(input int count);
    repeat (count) send_fresh(pick_value());
  endtask

  initial begin
    int stall;
    draw_t want;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = back_to_back ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (pending_draws.size() == 0) begin
        report_mismatch("unexpected shuffled_value", m_tdata[VALUE_W-1:0], '0);
      end else begin
        want = pending_draws.pop_front();
        if (m_tdata[VALUE_W-1:0] !== want.shuffled)
          report_mismatch("shuffled_value", m_tdata[VALUE_W-1:0], want.shuffled);
        if (m_tdata[VALUE_W +: MODULUS_BITS] !== want.generator)
          report_mismatch("generator_value", m_tdata[VALUE_W +: MODULUS_BITS], want.generator);
      end
      @(negedge clk);
    end
  end

  task automatic test_fill_and_extremes();
    send_fresh('0);
    send_fresh(VALUE_MAX);
    for (int i = 0; i < DEPTH - 2; i++) send_fresh(VALUE_W'(1) << i);
    send_fresh('0);
    send_fresh(VALUE_MAX);
    send_fresh(VALUE_W'(31'h5555_5555));
    send_fresh(VALUE_W'(31'h2AAA_AAAA));
    drain_results();
  endtask

  // A zero seed keeps the generator at zero, so entry 0 is chosen every time.
  task automatic test_seed_zero();
    write_reg(CFG_SEED, '0, 1'b1);
    send_burst(4);
    drain_results();
  endtask

  task automatic test_multiplier_extremes();
    write_reg(CFG_SEED, VALUE_MAX, 1'b0);
    write_reg(CFG_MULTIPLIER, VALUE_W'(1), 1'b1);
    send_burst(3);
    drain_results();
    write_reg(CFG_MULTIPLIER, VALUE_MAX, 1'b1);
    send_burst(3);
    drain_results();
    write_reg(CFG_MULTIPLIER, VALUE_W'(2), 1'b0);
    write_reg(CFG_SEED, VALUE_W'(1), 1'b1);
    send_burst(3);
    drain_results();
    write_reg(CFG_MULTIPLIER, '0, 1'b1);
    send_burst(2);
    drain_results();
  endtask

  task automatic test_ignored_index();
    write_reg(CFG_MULTIPLIER, VALUE_W'(24389), 1'b0);
    write_reg(CFG_SEED, VALUE_W'(12345), 1'b0);
    write_reg(CFG_UNUSED_LOW, VALUE_W'($urandom), 1'b0);
    write_reg(CFG_UNUSED_HIGH, VALUE_W'($urandom), 1'b1);
    send_burst(3);
    drain_results();
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      back_to_back = (phase % 3 == 1);
      case ($urandom_range(0, 2))
        0: write_reg(CFG_SEED, pick_value(), 1'b1);
        1: write_reg(CFG_MULTIPLIER, pick_value() | VALUE_W'(1), 1'b1);
        default: begin
          write_reg(CFG_MULTIPLIER, pick_value(), 1'b0);
          write_reg(CFG_SEED, pick_value(), 1'b1);
        end
      endcase
      send_burst(PHASE_ITEMS);
      drain_results();
    end
    back_to_back = 1'b0;
  endtask

  initial begin
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    back_to_back = 1'b0;
    mismatches   = 0;
    fill_level   = 0;
    gen_mult     = MULT_RESET;
    gen_state    = SEED_RESET;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_fill_and_extremes();
    test_seed_zero();
    test_multiplier_extremes();
    test_ignored_index();
    test_random_phases();

    if (mismatches == 0) begin
      $display("shuffled_mcg_generator_top_test OK");
    end else begin
      $display("shuffled_mcg_generator_top_test NOT OK");
    end
    $finish;
  end

endmodule
